[rtl/wav_header_parser_defines.svh]
// ----------------------------------------------------------------------------
// wav_header_parser_defines
// assertion macros used by the result unit of the wav header parser
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define WHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wav header parser assertion failed");

// next-cycle implication
`define WHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wav header parser assertion failed");

`endif

[rtl/whp_pkg.sv]
// ----------------------------------------------------------------------------
// whp_pkg
// types and constants of the wav header parser
// ----------------------------------------------------------------------------
package whp_pkg;

    typedef enum logic [2:0] {
        PH_FILE_HDR,
        PH_CHUNK_HDR,
        PH_FMT_BODY,
        PH_SKIP,
        PH_DONE,
        PH_ERR_HDR,
        PH_ERR_FMT,
        PH_ERR_DATA
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_OUT
    } t_back_state;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_HDR   = 3'd1;
    localparam logic [2:0] ST_SHORT_FMT = 3'd2;
    localparam logic [2:0] ST_MISSING   = 3'd3;
    localparam logic [2:0] ST_BAD_FMT   = 3'd4;

    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic [31:0] payload_offset;
        logic [31:0] payload_bytes;
    } t_job;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h52;
            4'd1:    b = 8'h49;
            4'd2:    b = 8'h46;
            4'd3:    b = 8'h46;
            4'd8:    b = 8'h57;
            4'd9:    b = 8'h41;
            4'd10:   b = 8'h56;
            4'd11:   b = 8'h45;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/whp_front.sv]
// ----------------------------------------------------------------------------
// whp_front
// byte parser: checks the riff header, walks chunks and queues one job per file
// ----------------------------------------------------------------------------
module whp_front import whp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_file,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [32:0] r_skip, n_skip;
    logic        r_hdr_ok, n_hdr_ok;
    logic        r_have, n_have;
    logic [15:0] r_ch, n_ch;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;

    logic        accept;
    logic [31:0] len_full;
    logic [32:0] skip_val;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign len_full = r_len | ({24'd0, i_data_byte} << {r_idx[1:0], 3'b000});

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_tag    = r_tag;
        n_len    = r_len;
        n_skip   = r_skip;
        n_hdr_ok = r_hdr_ok;
        n_have   = r_have;
        n_ch     = r_ch;
        n_rate   = r_rate;
        n_bits   = r_bits;
        o_push   = 1'b0;
        o_job    = '0;
        skip_val = '0;
        if (accept) begin
            n_pos = r_pos + 32'd1;
            case (r_phase)
                PH_FILE_HDR: begin
                    if ((r_idx < 4'd4 || r_idx >= 4'd8) && i_data_byte != hdr_byte(r_idx)) begin
                        n_hdr_ok = 1'b0;
                    end
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'd11) begin
                        n_idx   = '0;
                        n_phase = n_hdr_ok ? PH_CHUNK_HDR : PH_ERR_HDR;
                    end
                end
                PH_CHUNK_HDR: begin
                    if (r_idx < 4'd4) begin
                        n_tag = {r_tag[23:0], i_data_byte};
                    end else begin
                        n_len = len_full;
                    end
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'd7) begin
                        n_idx = '0;
                        n_len = '0;
                        if (r_tag == TAG_FMT) begin
                            n_len   = len_full;
                            n_phase = (len_full < 32'd16) ? PH_ERR_FMT : PH_FMT_BODY;
                        end else if (r_tag == TAG_DATA) begin
                            if (!r_have || r_ch == 16'd0 || r_bits < 16'd8) begin
                                n_phase = PH_ERR_DATA;
                            end else begin
                                o_push               = 1'b1;
                                o_job.status         = ST_OK;
                                o_job.channel_count  = r_ch;
                                o_job.rate_hz        = r_rate;
                                o_job.sample_bits    = r_bits;
                                o_job.payload_offset = r_pos + 32'd1;
                                o_job.payload_bytes  = len_full;
                                n_phase              = PH_DONE;
                            end
                        end else begin
                            skip_val = {1'b0, len_full} + {32'd0, len_full[0]};
                            n_skip   = skip_val;
                            n_phase  = (skip_val == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
                        end
                    end
                end
                PH_FMT_BODY: begin
                    case (r_idx)
                        4'd2:    n_ch[7:0]     = i_data_byte;
                        4'd3:    n_ch[15:8]    = i_data_byte;
                        4'd4:    n_rate[7:0]   = i_data_byte;
                        4'd5:    n_rate[15:8]  = i_data_byte;
                        4'd6:    n_rate[23:16] = i_data_byte;
                        4'd7:    n_rate[31:24] = i_data_byte;
                        4'd14:   n_bits[7:0]   = i_data_byte;
                        4'd15:   n_bits[15:8]  = i_data_byte;
                        default: ;
                    endcase
                    if (r_idx == 4'd2) begin
                        n_ch[15:8] = '0;
                    end
                    if (r_idx == 4'd4) begin
                        n_rate[31:8] = '0;
                    end
                    if (r_idx == 4'd14) begin
                        n_bits[15:8] = '0;
                    end
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'd15) begin
                        n_have   = 1'b1;
                        n_len    = '0;
                        n_idx    = '0;
                        skip_val = {1'b0, r_len} - 33'd16 + {32'd0, r_len[0]};
                        n_skip   = skip_val;
                        n_phase  = (skip_val == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 33'd1;
                    if (r_skip == 33'd1) begin
                        n_idx   = '0;
                        n_phase = PH_CHUNK_HDR;
                    end
                end
                default: ;
            endcase
            if (i_end_of_file) begin
                if (n_phase != PH_DONE) begin
                    o_push = 1'b1;
                    case (n_phase)
                        PH_FILE_HDR, PH_ERR_HDR:  o_job.status = ST_BAD_HDR;
                        PH_ERR_FMT, PH_FMT_BODY:  o_job.status = ST_SHORT_FMT;
                        PH_ERR_DATA:              o_job.status = n_have ? ST_BAD_FMT : ST_MISSING;
                        default:                  o_job.status = ST_MISSING;
                    endcase
                end
                n_phase  = PH_FILE_HDR;
                n_pos    = '0;
                n_idx    = '0;
                n_tag    = '0;
                n_len    = '0;
                n_skip   = '0;
                n_hdr_ok = 1'b1;
                n_have   = 1'b0;
                n_ch     = '0;
                n_rate   = '0;
                n_bits   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FILE_HDR;
            r_pos    <= '0;
            r_idx    <= '0;
            r_tag    <= '0;
            r_len    <= '0;
            r_skip   <= '0;
            r_hdr_ok <= 1'b1;
            r_have   <= 1'b0;
            r_ch     <= '0;
            r_rate   <= '0;
            r_bits   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_idx    <= n_idx;
            r_tag    <= n_tag;
            r_len    <= n_len;
            r_skip   <= n_skip;
            r_hdr_ok <= n_hdr_ok;
            r_have   <= n_have;
            r_ch     <= n_ch;
            r_rate   <= n_rate;
            r_bits   <= n_bits;
        end
    end

endmodule

[rtl/whp_queue.sv]
// ----------------------------------------------------------------------------
// whp_queue
// two-entry job queue between the byte parser and the result unit
// ----------------------------------------------------------------------------
module whp_queue import whp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[rtl/whp_back.sv]
// ----------------------------------------------------------------------------
// whp_back
// result unit: frame size multiply, serial frame count divide, output register
// ----------------------------------------------------------------------------
`include "wav_header_parser_defines.svh"

module whp_back import whp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_rate_hz,
    output logic [15:0] o_sample_bits,
    output logic [31:0] o_payload_offset,
    output logic [31:0] o_payload_bytes,
    output logic [31:0] o_frame_count
);

    t_back_state r_state, n_state;
    t_job        r_out, n_out;
    logic [28:0] r_per, n_per;
    logic [28:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [4:0]  r_cnt, n_cnt;
    logic [29:0] trial;

    assign trial = {r_rem, r_quo[31]};

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_per   = r_per;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        o_pop   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_out = i_q_job;
                    n_quo = '0;
                    n_state = (i_q_job.status == ST_OK) ? BK_MUL : BK_OUT;
                end
            end
            BK_MUL: begin
                n_per   = 29'({13'd0, r_out.channel_count} * {16'd0, r_out.sample_bits[15:3]});
                n_quo   = r_out.payload_bytes;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = BK_DIV;
            end
            BK_DIV: begin
                if (trial >= {1'b0, r_per}) begin
                    n_rem = 29'(trial - {1'b0, r_per});
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = trial[28:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (i_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_per <= n_per;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    assign o_valid          = (r_state == BK_OUT);
    assign o_status         = r_out.status;
    assign o_channel_count  = r_out.channel_count;
    assign o_rate_hz        = r_out.rate_hz;
    assign o_sample_bits    = r_out.sample_bits;
    assign o_payload_offset = r_out.payload_offset;
    assign o_payload_bytes  = r_out.payload_bytes;
    assign o_frame_count    = r_quo;

    `WHP_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == BK_DIV, r_per != 29'd0)
    `WHP_ASSERT_NXT(a_div_ends, i_clk, i_rst_n, r_state == BK_DIV && r_cnt == 5'd31,
        r_state == BK_OUT)
    `WHP_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK,
        o_frame_count == 32'd0 && o_payload_bytes == 32'd0 && o_channel_count == 16'd0)

endmodule

[rtl/wav_header_parser.sv]
// ----------------------------------------------------------------------------
// wav_header_parser
// streaming riff/wave header parser, one result per file
// ----------------------------------------------------------------------------
// input channel: i_valid/o_ready with i_data_byte and i_end_of_file, one file
// byte per transaction, the last byte of each file marked by i_end_of_file.
// output channel: o_valid/i_ready with status, format fields, payload offset,
// payload byte count and frame count; at most one transaction per file.
// the byte parser takes one byte per cycle while its two-entry job queue has
// room. an ok result is queued at the last byte of the data chunk header, an
// error result at the end_of_file byte; later bytes of a finished file are
// dropped until the end_of_file byte.
// an error job goes from the queue straight to the output register; an ok
// job first passes a multiply state for the frame size, then a radix-2
// serial divider for the frame count. the next job leaves the queue only
// once the result before it has been taken.
// when the receiver stalls the result holds in the output register, the queue
// fills and o_ready drops only once two more jobs are waiting.
// synchronous reset returns the parser to the start of a file and empties
// the queue and the output register.
// ----------------------------------------------------------------------------
module wav_header_parser import whp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_rate_hz,
    output logic [15:0] o_sample_bits,
    output logic [31:0] o_payload_offset,
    output logic [31:0] o_payload_bytes,
    output logic [31:0] o_frame_count
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job push_job;
    t_job head_job;

    whp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (push_job)
    );

    whp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    whp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_job          (head_job),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_channel_count  (o_channel_count),
        .o_rate_hz        (o_rate_hz),
        .o_sample_bits    (o_sample_bits),
        .o_payload_offset (o_payload_offset),
        .o_payload_bytes  (o_payload_bytes),
        .o_frame_count    (o_frame_count)
    );

endmodule

[verif/wav_header_parser_tb.sv]
// ----------------------------------------------------------------------------
// wav_header_parser_tb
// self-checking testbench of the streaming wav header parser
// ----------------------------------------------------------------------------
// builds wav files as byte streams and sends them one byte per transaction:
// directed files for header, format and chunk-walk errors and for the field
// extremes, then random files, most of them well formed with random content
// and the rest noise, truncated or bit-flipped. a byte-level parser in the
// testbench predicts each result and a monitor checks every result
// transaction field by field, in order. both sides idle and stall at random.
// ----------------------------------------------------------------------------
module wav_header_parser_tb import whp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [95:0] RIFF_HEAD = {32'h52494646, 32'h00000000, 32'h57415645};
    localparam logic [31:0] TAG_RIFF  = 32'h52494646;
    localparam logic [31:0] TAG_WAVE  = 32'h57415645;
    localparam logic [31:0] TAG_LIST  = 32'h4C495354;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic [31:0] payload_offset;
        logic [31:0] payload_bytes;
        logic [31:0] frame_count;
    } t_wav_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_end_of_file;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [15:0] o_channel_count;
    logic [31:0] o_rate_hz;
    logic [15:0] o_sample_bits;
    logic [31:0] o_payload_offset;
    logic [31:0] o_payload_bytes;
    logic [31:0] o_frame_count;

    t_wav_report expected_reports[$];
    t_wav_report next_report;
    logic [7:0]  file_bytes[$];
    int          error_count = 0;
    int          sent_bytes = 0;
    bit          steady_send = 1'b0;

    // parser state of the prediction
    t_phase      prs_phase;
    logic [31:0] prs_pos;
    int          prs_idx;
    logic [31:0] prs_tag;
    logic [31:0] prs_len;
    logic [32:0] prs_skip;
    logic        prs_hdr_ok;
    logic        prs_have_fmt;
    logic [15:0] prs_channels;
    logic [31:0] prs_rate;
    logic [15:0] prs_bits;
    logic        prs_finished;

    wav_header_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_file    (i_end_of_file),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_channel_count  (o_channel_count),
        .o_rate_hz        (o_rate_hz),
        .o_sample_bits    (o_sample_bits),
        .o_payload_offset (o_payload_offset),
        .o_payload_bytes  (o_payload_bytes),
        .o_frame_count    (o_frame_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic void restart_parse();
        prs_phase    = PH_FILE_HDR;
        prs_pos      = '0;
        prs_idx      = 0;
        prs_tag      = '0;
        prs_len      = '0;
        prs_skip     = '0;
        prs_hdr_ok   = 1'b1;
        prs_have_fmt = 1'b0;
        prs_channels = '0;
        prs_rate     = '0;
        prs_bits     = '0;
        prs_finished = 1'b0;
    endfunction

    function automatic void start_skip(input logic [32:0] n);
        prs_skip  = n;
        prs_idx   = 0;
        prs_phase = (n == 0) ? PH_CHUNK_HDR : PH_SKIP;
    endfunction

    function automatic void parse_wav_byte(input logic [7:0] b, input logic eof);
        logic [31:0] pos;
        logic [31:0] len;
        logic [63:0] frame_size;
        t_wav_report rep;
        logic        have_rep;
        pos      = prs_pos;
        rep      = '0;
        have_rep = 1'b0;
        prs_pos  = prs_pos + 32'd1;
        case (prs_phase)
            PH_FILE_HDR: begin
                if ((prs_idx < 4 || prs_idx >= 8) && b != RIFF_HEAD[95 - 8 * prs_idx -: 8])
                    prs_hdr_ok = 1'b0;
                prs_idx++;
                if (prs_idx >= 12) begin
                    prs_idx   = 0;
                    prs_phase = prs_hdr_ok ? PH_CHUNK_HDR : PH_ERR_HDR;
                end
            end
            PH_CHUNK_HDR: begin
                if (prs_idx < 4)
                    prs_tag = {prs_tag[23:0], b};
                else
                    prs_len[8 * (prs_idx - 4) +: 8] = b;
                prs_idx++;
                if (prs_idx >= 8) begin
                    len     = prs_len;
                    prs_idx = 0;
                    prs_len = '0;
                    if (prs_tag == TAG_FMT) begin
                        prs_len   = len;
                        prs_phase = (len < 16) ? PH_ERR_FMT : PH_FMT_BODY;
                    end else if (prs_tag == TAG_DATA) begin
                        if (!prs_have_fmt || prs_channels == 0 || prs_bits < 16'd8) begin
                            prs_phase = PH_ERR_DATA;
                        end else begin
                            frame_size         = 64'(prs_channels) * 64'(prs_bits >> 3);
                            rep.status         = ST_OK;
                            rep.channel_count  = prs_channels;
                            rep.rate_hz        = prs_rate;
                            rep.sample_bits    = prs_bits;
                            rep.payload_offset = pos + 32'd1;
                            rep.payload_bytes  = len;
                            rep.frame_count    = 32'(64'(len) / frame_size);
                            have_rep           = 1'b1;
                            prs_finished       = 1'b1;
                            prs_phase          = PH_DONE;
                        end
                    end else begin
                        start_skip(33'(len) + 33'(len[0]));
                    end
                end
            end
            PH_FMT_BODY: begin
                case (prs_idx)
                    2:  prs_channels       = {8'h00, b};
                    3:  prs_channels[15:8] = b;
                    4:  prs_rate           = {24'h000000, b};
                    5:  prs_rate[15:8]     = b;
                    6:  prs_rate[23:16]    = b;
                    7:  prs_rate[31:24]    = b;
                    14: prs_bits           = {8'h00, b};
                    15: prs_bits[15:8]     = b;
                    default: ;
                endcase
                prs_idx++;
                if (prs_idx >= 16) begin
                    len          = prs_len;
                    prs_have_fmt = 1'b1;
                    prs_len      = '0;
                    start_skip(33'(len) - 33'd16 + 33'(len[0]));
                end
            end
            PH_SKIP: begin
                if (prs_skip > 0)
                    prs_skip = prs_skip - 33'd1;
                if (prs_skip == 0) begin
                    prs_idx   = 0;
                    prs_phase = PH_CHUNK_HDR;
                end
            end
            default: ;
        endcase
        if (eof) begin
            if (!have_rep && !prs_finished) begin
                rep = '0;
                case (prs_phase)
                    PH_FILE_HDR, PH_ERR_HDR: rep.status = ST_BAD_HDR;
                    PH_ERR_FMT, PH_FMT_BODY: rep.status = ST_SHORT_FMT;
                    PH_ERR_DATA:             rep.status = prs_have_fmt ? ST_BAD_FMT : ST_MISSING;
                    default:                 rep.status = ST_MISSING;
                endcase
                have_rep = 1'b1;
            end
            restart_parse();
        end
        if (have_rep)
            expected_reports.push_back(rep);
    endfunction

    // mostly no idling, some short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void add_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void add_tag(input logic [31:0] tag);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(tag[8 * i +: 8]);
    endfunction

    function automatic void add_random(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void start_riff();
        file_bytes.delete();
        add_tag(TAG_RIFF);
        add_le($urandom, 4);
        add_tag(TAG_WAVE);
    endfunction

    function automatic void add_chunk(input logic [31:0] tag, input int len);
        add_tag(tag);
        add_le(32'(len), 4);
        add_random(len + (len % 2));
    endfunction

    function automatic void add_fmt(input int len, input logic [15:0] channels,
                                    input logic [31:0] rate, input logic [15:0] bits);
        add_tag(TAG_FMT);
        add_le(32'(len), 4);
        add_random(2);
        add_le(32'(channels), 2);
        add_le(rate, 4);
        add_random(6);
        add_le(32'(bits), 2);
        add_random(len - 16 + (len % 2));
    endfunction

    function automatic void add_data(input logic [31:0] len);
        add_tag(TAG_DATA);
        add_le(len, 4);
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = steady_send ? 0 : idle_cycles();
        if (gap > 0) begin
            i_valid       <= 1'b0;
            i_data_byte   <= 8'($urandom);
            i_end_of_file <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (!o_ready);
        sent_bytes++;
        parse_wav_byte(b, eof);
        @(negedge i_clk);
    endtask

    // keep = 0 sends the whole file, otherwise the file is cut after keep bytes
    task automatic send_file(input int keep);
        int n;
        n = (keep > 0 && keep < file_bytes.size()) ? keep : file_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], i == n - 1);
    endtask

    task automatic test_header_errors();
        file_bytes.delete();
        add_random(1);
        send_file(0);
        start_riff();
        send_file(5);
        start_riff();
        send_file(12);
        file_bytes.delete();
        repeat (12) file_bytes.push_back(8'hFF);
        add_fmt(16, 16'd2, 32'd44100, 16'd16);
        add_data(32'd1000);
        send_file(0);
        file_bytes.delete();
        repeat (20) file_bytes.push_back(8'h00);
        send_file(0);
        start_riff();
        file_bytes[11] = 8'h00;
        add_fmt(16, 16'd2, 32'd44100, 16'd16);
        add_data(32'd1000);
        send_file(0);
    endtask

    task automatic test_format_errors();
        start_riff();
        add_chunk(TAG_FMT, 15);
        add_data(32'd64);
        send_file(0);
        start_riff();
        add_chunk(TAG_FMT, 0);
        add_random(3);
        send_file(0);
        start_riff();
        add_fmt(16, 16'd2, 32'd48000, 16'd16);
        send_file(30);
        start_riff();
        add_chunk(TAG_LIST, 3);
        add_data(32'd64);
        add_random(5);
        send_file(0);
        start_riff();
        add_fmt(16, 16'd0, 32'd48000, 16'd16);
        add_data(32'd100);
        add_random(2);
        send_file(0);
        start_riff();
        add_fmt(16, 16'd2, 32'd48000, 16'd7);
        add_data(32'd100);
        send_file(0);
        start_riff();
        add_fmt(16, 16'd1, 32'd8000, 16'd0);
        add_data(32'd100);
        send_file(0);
        start_riff();
        add_tag(TAG_LIST);
        add_le(32'hFFFF_FFFF, 4);
        add_random(10);
        send_file(0);
        start_riff();
        add_tag(TAG_FMT);
        add_le(32'hFFFF_FFFF, 4);
        add_random(20);
        send_file(0);
        start_riff();
        add_chunk(TAG_LIST, 2);
        add_tag(TAG_DATA);
        add_random(2);
        send_file(0);
    endtask

    task automatic test_valid_files();
        start_riff();
        add_fmt(16, 16'd1, 32'd8000, 16'd8);
        add_data(32'd100);
        add_random(3);
        send_file(0);
        start_riff();
        add_chunk(TAG_LIST, 1);
        add_fmt(17, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_data(32'hFFFF_FFFF);
        send_file(0);
        start_riff();
        add_fmt(16, 16'd2, 32'd44100, 16'd16);
        add_chunk(TAG_LIST, 0);
        add_fmt(18, 16'd6, 32'd96000, 16'd24);
        add_data(32'd18005);
        add_random(8);
        send_file(0);
        start_riff();
        add_fmt(16, 16'd2, 32'd22050, 16'd32);
        add_data(32'd0);
        add_random(1);
        send_file(0);
        start_riff();
        add_fmt(20, 16'd3, 32'd11025, 16'd15);
        add_data(32'd1001);
        add_random(2);
        send_file(0);
    endtask

    task automatic test_random_files();
        int          kind;
        int          pos;
        int          fmt_len;
        logic [15:0] channels;
        logic [15:0] bits;
        while (sent_bytes < 1550) begin
            kind        = $urandom_range(0, 99);
            steady_send = ($urandom_range(0, 7) == 0);
            if (kind < 10) begin
                file_bytes.delete();
                add_random($urandom_range(1, 30));
            end else begin
                start_riff();
                repeat ($urandom_range(0, 2))
                    add_chunk($urandom_range(0, 1) ? TAG_LIST : 32'($urandom),
                              $urandom_range(0, 6));
                repeat ($urandom_range(1, 2)) begin
                    fmt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 22) : 16;
                    pos = $urandom_range(0, 99);
                    channels = (pos < 80) ? 16'($urandom_range(1, 8)) :
                               (pos < 90) ? 16'($urandom) : 16'd0;
                    pos = $urandom_range(0, 99);
                    bits = (pos < 70) ? 16'(8 * $urandom_range(1, 4)) :
                           (pos < 85) ? 16'($urandom_range(0, 7)) : 16'($urandom);
                    add_fmt(fmt_len, channels, $urandom, bits);
                end
                if ($urandom_range(0, 3) == 0)
                    add_chunk(TAG_LIST, $urandom_range(0, 5));
                add_data($urandom_range(0, 1) ? 32'($urandom_range(0, 4096)) : $urandom);
                add_random($urandom_range(0, 4));
                if (kind < 25) begin
                    pos = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes[pos] = file_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
                end
            end
            send_file(($urandom_range(0, 9) == 0) ? $urandom_range(1, file_bytes.size()) : 0);
        end
        steady_send = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                $error("result transaction with none expected, status %0d", o_status);
                error_count++;
            end else begin
                next_report = expected_reports.pop_front();
                check_field("status", 32'(next_report.status), 32'(o_status));
                check_field("channel_count", 32'(next_report.channel_count),
                            32'(o_channel_count));
                check_field("rate_hz", next_report.rate_hz, o_rate_hz);
                check_field("sample_bits", 32'(next_report.sample_bits), 32'(o_sample_bits));
                check_field("payload_offset", next_report.payload_offset, o_payload_offset);
                check_field("payload_bytes", next_report.payload_bytes, o_payload_bytes);
                check_field("frame_count", next_report.frame_count, o_frame_count);
            end
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        int run;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                @(negedge i_clk) i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
            @(negedge i_clk) i_ready <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
        end
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = '0;
        i_end_of_file = 1'b0;
        restart_parse();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_header_errors();
        test_format_errors();
        test_valid_files();
        test_random_files();
        i_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
